// ----- hw/rtl/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, codes and constants for the signature envelope deframer.
// ----------------------------------------------------------------------------
package sed_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_SCHEME,
    PH_KLEN_HI,
    PH_KLEN_LO,
    PH_KEY,
    PH_SLEN_HI,
    PH_SLEN_LO,
    PH_SIG,
    PH_CKEY,
    PH_CSIG,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_MAGIC,
    ST_SCHEME,
    ST_KEYLEN,
    ST_SIGLEN,
    ST_TRUNC,
    ST_TRAIL
  } status_t;

  typedef enum logic [2:0] {
    KIND_HDR,
    KIND_KEY,
    KIND_SIG,
    KIND_CKEY,
    KIND_CSIG,
    KIND_DISCARD
  } kind_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_KEY_L2 = 3'd0;
  localparam logic [2:0] REG_SIG_L2 = 3'd1;
  localparam logic [2:0] REG_KEY_L3 = 3'd2;
  localparam logic [2:0] REG_SIG_L3 = 3'd3;
  localparam logic [2:0] REG_KEY_L5 = 3'd4;
  localparam logic [2:0] REG_SIG_L5 = 3'd5;

  localparam logic [15:0] RST_KEY_L2 = 16'd1312;
  localparam logic [15:0] RST_SIG_L2 = 16'd2420;
  localparam logic [15:0] RST_KEY_L3 = 16'd1952;
  localparam logic [15:0] RST_SIG_L3 = 16'd3309;
  localparam logic [15:0] RST_KEY_L5 = 16'd2592;
  localparam logic [15:0] RST_SIG_L5 = 16'd4627;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h44, 8'h50, 8'h51, 8'h31};

  localparam logic [7:0] HYBRID_BIT    = 8'h10;
  localparam logic [7:0] LEVEL_MASK    = 8'h0F;
  localparam logic [7:0] RESERVED_MASK = 8'hE0;
  localparam logic [15:0] CL_KEY_BYTES = 16'd32;
  localparam logic [15:0] CL_SIG_BYTES = 16'd64;

  localparam logic [7:0] LEVEL_2 = 8'h01;
  localparam logic [7:0] LEVEL_3 = 8'h02;
  localparam logic [7:0] LEVEL_5 = 8'h03;

  typedef struct packed {
    logic [15:0] key_l2;
    logic [15:0] sig_l2;
    logic [15:0] key_l3;
    logic [15:0] sig_l3;
    logic [15:0] key_l5;
    logic [15:0] sig_l5;
  } cfg_t;

  typedef struct packed {
    kind_t       byte_kind;
    logic [7:0]  byte_value;
    logic        verdict_valid;
    status_t     status;
    logic [7:0]  scheme_code;
    logic        hybrid_flag;
  } result_t;

  function automatic logic scheme_ok(input logic [7:0] s);
    logic [7:0] lv;
    lv = s & LEVEL_MASK;
    return ((lv == LEVEL_2) || (lv == LEVEL_3) || (lv == LEVEL_5)) &&
           ((s & RESERVED_MASK) == 8'h00);
  endfunction

  function automatic logic [15:0] expected_len(input cfg_t c, input logic [7:0] s,
                                               input logic sig);
    logic [15:0] r;
    case (s & LEVEL_MASK)
      LEVEL_2: r = sig ? c.sig_l2 : c.key_l2;
      LEVEL_3: r = sig ? c.sig_l3 : c.key_l3;
      LEVEL_5: r = sig ? c.sig_l5 : c.key_l5;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/sed_if.sv -----
// ----------------------------------------------------------------------------
// sed_in_if / sed_out_if
// Valid/ready channels carrying envelope bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] env_byte;
  logic       is_final;

  modport source (output valid, output env_byte, output is_final, input ready);
  modport sink   (input valid, input env_byte, input is_final, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_kind;
  logic [7:0] byte_value;
  logic       verdict_valid;
  logic [2:0] status;
  logic [7:0] scheme_code;
  logic       hybrid_flag;

  modport source (output valid, output byte_kind, output byte_value, output verdict_valid,
                  output status, output scheme_code, output hybrid_flag, input ready);
  modport sink   (input valid, input byte_kind, input byte_value, input verdict_valid,
                  input status, input scheme_code, input hybrid_flag, output ready);
endinterface

// ----- hw/rtl/sed_cfg.sv -----
// ----------------------------------------------------------------------------
// sed_cfg
// APB register file holding the expected key and signature lengths.
// ----------------------------------------------------------------------------
module sed_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sed_pkg::ADDR_W-1:0]   paddr,
  input  logic [sed_pkg::DATA_W-1:0]   pwdata,
  output logic [sed_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output sed_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;
  logic [15:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_l2 <= sed_pkg::RST_KEY_L2;
      cfg.sig_l2 <= sed_pkg::RST_SIG_L2;
      cfg.key_l3 <= sed_pkg::RST_KEY_L3;
      cfg.sig_l3 <= sed_pkg::RST_SIG_L3;
      cfg.key_l5 <= sed_pkg::RST_KEY_L5;
      cfg.sig_l5 <= sed_pkg::RST_SIG_L5;
    end else if (wr_en) begin
      case (reg_idx)
        sed_pkg::REG_KEY_L2: cfg.key_l2 <= pwdata[15:0];
        sed_pkg::REG_SIG_L2: cfg.sig_l2 <= pwdata[15:0];
        sed_pkg::REG_KEY_L3: cfg.key_l3 <= pwdata[15:0];
        sed_pkg::REG_SIG_L3: cfg.sig_l3 <= pwdata[15:0];
        sed_pkg::REG_KEY_L5: cfg.key_l5 <= pwdata[15:0];
        sed_pkg::REG_SIG_L5: cfg.sig_l5 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sed_pkg::REG_KEY_L2: rd_val = cfg.key_l2;
      sed_pkg::REG_SIG_L2: rd_val = cfg.sig_l2;
      sed_pkg::REG_KEY_L3: rd_val = cfg.key_l3;
      sed_pkg::REG_SIG_L3: rd_val = cfg.sig_l3;
      sed_pkg::REG_KEY_L5: rd_val = cfg.key_l5;
      sed_pkg::REG_SIG_L5: rd_val = cfg.sig_l5;
      default:             rd_val = 16'd0;
    endcase
  end

  assign prdata = {16'd0, rd_val};

endmodule

// ----- hw/rtl/sed_core.sv -----
// ----------------------------------------------------------------------------
// sed_core
// Input register, field tracking state machine and result register.
// ----------------------------------------------------------------------------
module sed_core (
  input  logic          clk,
  input  logic          rst,
  input  sed_pkg::cfg_t cfg,
  sed_in_if.sink        in_ch,
  sed_out_if.source     out_ch
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_final;
  logic        advance;

  sed_pkg::phase_t  phase, phase_next;
  logic [15:0]      byte_count, byte_count_next;
  logic [7:0]       scheme_held, scheme_held_next;
  logic [7:0]       length_high, length_high_next;
  sed_pkg::status_t error_held, error_held_next;

  logic              out_valid;
  sed_pkg::result_t  out_res, res_next;

  logic [15:0] len_word;
  logic [15:0] cnt_dec;
  logic [15:0] cnt_inc;
  logic        hybrid;

  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  assign len_word = {length_high, in_byte};
  assign cnt_dec  = byte_count - 16'd1;
  assign cnt_inc  = byte_count + 16'd1;
  assign hybrid   = (scheme_held & sed_pkg::HYBRID_BIT) != 8'h00;

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    scheme_held_next = scheme_held;
    length_high_next = length_high;
    error_held_next  = error_held;
    res_next.byte_kind = sed_pkg::KIND_HDR;

    case (phase)
      sed_pkg::PH_MAGIC: begin
        if (in_byte != sed_pkg::MAGIC_BYTES[byte_count[1:0]]) begin
          error_held_next = sed_pkg::ST_MAGIC;
          phase_next      = sed_pkg::PH_FAIL;
        end else if (byte_count[1:0] == 2'd3) begin
          byte_count_next = 16'd0;
          phase_next      = sed_pkg::PH_SCHEME;
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      sed_pkg::PH_SCHEME: begin
        scheme_held_next = in_byte;
        if (sed_pkg::scheme_ok(in_byte)) begin
          phase_next = sed_pkg::PH_KLEN_HI;
        end else begin
          error_held_next = sed_pkg::ST_SCHEME;
          phase_next      = sed_pkg::PH_FAIL;
        end
      end
      sed_pkg::PH_KLEN_HI: begin
        length_high_next = in_byte;
        phase_next       = sed_pkg::PH_KLEN_LO;
      end
      sed_pkg::PH_KLEN_LO: begin
        if (len_word != sed_pkg::expected_len(cfg, scheme_held, 1'b0)) begin
          error_held_next = sed_pkg::ST_KEYLEN;
          phase_next      = sed_pkg::PH_FAIL;
        end else if (len_word == 16'd0) begin
          phase_next = sed_pkg::PH_SLEN_HI;
        end else begin
          byte_count_next = len_word;
          phase_next      = sed_pkg::PH_KEY;
        end
      end
      sed_pkg::PH_KEY: begin
        res_next.byte_kind = sed_pkg::KIND_KEY;
        byte_count_next    = cnt_dec;
        if (cnt_dec == 16'd0) phase_next = sed_pkg::PH_SLEN_HI;
      end
      sed_pkg::PH_SLEN_HI: begin
        length_high_next = in_byte;
        phase_next       = sed_pkg::PH_SLEN_LO;
      end
      sed_pkg::PH_SLEN_LO: begin
        if (len_word != sed_pkg::expected_len(cfg, scheme_held, 1'b1)) begin
          error_held_next = sed_pkg::ST_SIGLEN;
          phase_next      = sed_pkg::PH_FAIL;
        end else if (len_word == 16'd0) begin
          if (hybrid) begin
            phase_next      = sed_pkg::PH_CKEY;
            byte_count_next = sed_pkg::CL_KEY_BYTES;
          end else begin
            phase_next = sed_pkg::PH_DONE;
          end
        end else begin
          byte_count_next = len_word;
          phase_next      = sed_pkg::PH_SIG;
        end
      end
      sed_pkg::PH_SIG: begin
        res_next.byte_kind = sed_pkg::KIND_SIG;
        byte_count_next    = cnt_dec;
        if (cnt_dec == 16'd0) begin
          if (hybrid) begin
            phase_next      = sed_pkg::PH_CKEY;
            byte_count_next = sed_pkg::CL_KEY_BYTES;
          end else begin
            phase_next = sed_pkg::PH_DONE;
          end
        end
      end
      sed_pkg::PH_CKEY: begin
        res_next.byte_kind = sed_pkg::KIND_CKEY;
        byte_count_next    = cnt_dec;
        if (cnt_dec == 16'd0) begin
          phase_next      = sed_pkg::PH_CSIG;
          byte_count_next = sed_pkg::CL_SIG_BYTES;
        end
      end
      sed_pkg::PH_CSIG: begin
        res_next.byte_kind = sed_pkg::KIND_CSIG;
        byte_count_next    = cnt_dec;
        if (cnt_dec == 16'd0) phase_next = sed_pkg::PH_DONE;
      end
      sed_pkg::PH_DONE: begin
        res_next.byte_kind = sed_pkg::KIND_DISCARD;
        error_held_next    = sed_pkg::ST_TRAIL;
        phase_next         = sed_pkg::PH_FAIL;
      end
      default: begin
        res_next.byte_kind = sed_pkg::KIND_DISCARD;
      end
    endcase

    res_next.byte_value    = in_byte;
    res_next.verdict_valid = in_final;
    res_next.status        = sed_pkg::ST_OK;
    res_next.scheme_code   = 8'h00;
    res_next.hybrid_flag   = 1'b0;

    if (in_final) begin
      if (phase_next == sed_pkg::PH_FAIL) begin
        res_next.status = error_held_next;
      end else if (phase_next == sed_pkg::PH_DONE) begin
        res_next.status = sed_pkg::ST_OK;
      end else begin
        res_next.status = sed_pkg::ST_TRUNC;
      end
      res_next.scheme_code = scheme_held_next;
      res_next.hybrid_flag = (scheme_held_next & sed_pkg::HYBRID_BIT) != 8'h00;
      // envelope closed, start over
      phase_next       = sed_pkg::PH_MAGIC;
      byte_count_next  = 16'd0;
      scheme_held_next = 8'h00;
      length_high_next = 8'h00;
      error_held_next  = sed_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= sed_pkg::PH_MAGIC;
      byte_count  <= 16'd0;
      scheme_held <= 8'h00;
      length_high <= 8'h00;
      error_held  <= sed_pkg::ST_OK;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        scheme_held <= scheme_held_next;
        length_high <= length_high_next;
        error_held  <= error_held_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte  <= in_ch.env_byte;
      in_final <= in_ch.is_final;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.byte_kind     = out_res.byte_kind;
  assign out_ch.byte_value    = out_res.byte_value;
  assign out_ch.verdict_valid = out_res.verdict_valid;
  assign out_ch.status        = out_res.status;
  assign out_ch.scheme_code   = out_res.scheme_code;
  assign out_ch.hybrid_flag   = out_res.hybrid_flag;

endmodule

// ----- hw/rtl/signature_envelope_deframer.sv -----
// ----------------------------------------------------------------------------
// signature_envelope_deframer
// Tags each envelope byte with its field and gives a verdict on the last one.
// ----------------------------------------------------------------------------
// a result passes through the input register and then the result register
// throughput: one byte per cycle while the result channel is not stalled, set by the field state update
// a stalled result holds the input register, so the input stalls once
// both registers are full
// reset (rst, synchronous): parser returns to the magic field, length
// registers return to their default values, both channels empty
module signature_envelope_deframer (
  input  logic                        clk,
  input  logic                        rst,
  sed_in_if.sink                      in_ch,
  sed_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sed_pkg::ADDR_W-1:0]  paddr,
  input  logic [sed_pkg::DATA_W-1:0]  pwdata,
  output logic [sed_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  sed_pkg::cfg_t cfg;

  sed_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sed_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/sed_checker.sv -----
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] byte_kind,
  input logic [7:0] byte_value,
  input logic       verdict_valid,
  input logic [2:0] status,
  input logic [7:0] scheme_code,
  input logic       hybrid_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(byte_kind) &&
      $stable(verdict_valid) && $stable(status))
    else $error("result changed while stalled");

  a_no_verdict_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !verdict_valid |->
      status == sed_pkg::ST_OK && scheme_code == 8'h00 && !hybrid_flag)
    else $error("verdict fields set without verdict");

  a_hybrid_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_valid |-> hybrid_flag == scheme_code[4])
    else $error("hybrid flag does not follow scheme");

  a_ok_hybrid_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_valid && status == sed_pkg::ST_OK && hybrid_flag |->
      byte_kind == sed_pkg::KIND_CSIG)
    else $error("hybrid envelope accepted without classical tail");

  a_ok_scheme_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict_valid && status == sed_pkg::ST_OK |->
      sed_pkg::scheme_ok(scheme_code))
    else $error("envelope accepted with bad scheme");

endmodule

bind signature_envelope_deframer sed_checker u_sed_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .byte_kind     (out_ch.byte_kind),
  .byte_value    (out_ch.byte_value),
  .verdict_valid (out_ch.verdict_valid),
  .status        (out_ch.status),
  .scheme_code   (out_ch.scheme_code),
  .hybrid_flag   (out_ch.hybrid_flag)
);

// ----- tb/deframer_checker.sv -----
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte and tag channels and the register port of the envelope
// deframer. A model of the field parser predicts the tag and verdict of every
// accepted envelope byte, and each tagged byte that leaves the block is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module deframer_checker
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sed_in_if                 in_ch,
  sed_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatches,
  output int unsigned       tags_due,
  output int unsigned       verdicts_ok,
  output int unsigned       verdicts_bad
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        lens;
  phase_t      field;
  logic [15:0] left;
  logic [7:0]  scheme_seen;
  logic [7:0]  len_hi;
  status_t     first_err;
  result_t     tags_owed[$];

  function automatic logic [15:0] level_len(input logic [7:0] s, input logic sig);
    case (s & LEVEL_MASK)
      LEVEL_2: return sig ? lens.sig_l2 : lens.key_l2;
      LEVEL_3: return sig ? lens.sig_l3 : lens.key_l3;
      LEVEL_5: return sig ? lens.sig_l5 : lens.key_l5;
      default: return 16'd0;
    endcase
  endfunction

  task automatic restart_envelope();
    field = PH_MAGIC;
    left = 16'd0;
    scheme_seen = 8'h00;
    len_hi = 8'h00;
    first_err = ST_OK;
  endtask

  task automatic mark_error(input status_t code);
    first_err = code;
    field = PH_FAIL;
  endtask

  task automatic close_signature();
    if ((scheme_seen & HYBRID_BIT) != 8'h00) begin
      field = PH_CKEY;
      left = CL_KEY_BYTES;
    end else begin
      field = PH_DONE;
    end
  endtask

  task automatic parse_envelope_byte(input logic [7:0] b, input logic fin, output result_t r);
    logic [15:0] len;
    r = '0;
    r.byte_kind = KIND_HDR;
    r.byte_value = b;
    case (field)
      PH_MAGIC: begin
        if (b != MAGIC_BYTES[left[1:0]]) begin
          mark_error(ST_MAGIC);
        end else begin
          left = left + 16'd1;
          if (left >= 16'd4) begin
            left = 16'd0;
            field = PH_SCHEME;
          end
        end
      end
      PH_SCHEME: begin
        scheme_seen = b;
        if (((b & LEVEL_MASK) == LEVEL_2 || (b & LEVEL_MASK) == LEVEL_3 ||
             (b & LEVEL_MASK) == LEVEL_5) && (b & RESERVED_MASK) == 8'h00) begin
          field = PH_KLEN_HI;
        end else begin
          mark_error(ST_SCHEME);
        end
      end
      PH_KLEN_HI: begin
        len_hi = b;
        field = PH_KLEN_LO;
      end
      PH_KLEN_LO: begin
        len = {len_hi, b};
        if (len != level_len(scheme_seen, 1'b0)) begin
          mark_error(ST_KEYLEN);
        end else if (len == 16'd0) begin
          field = PH_SLEN_HI;
        end else begin
          left = len;
          field = PH_KEY;
        end
      end
      PH_KEY: begin
        r.byte_kind = KIND_KEY;
        left = left - 16'd1;
        if (left == 16'd0) field = PH_SLEN_HI;
      end
      PH_SLEN_HI: begin
        len_hi = b;
        field = PH_SLEN_LO;
      end
      PH_SLEN_LO: begin
        len = {len_hi, b};
        if (len != level_len(scheme_seen, 1'b1)) begin
          mark_error(ST_SIGLEN);
        end else if (len == 16'd0) begin
          close_signature();
        end else begin
          left = len;
          field = PH_SIG;
        end
      end
      PH_SIG: begin
        r.byte_kind = KIND_SIG;
        left = left - 16'd1;
        if (left == 16'd0) close_signature();
      end
      PH_CKEY: begin
        r.byte_kind = KIND_CKEY;
        left = left - 16'd1;
        if (left == 16'd0) begin
          field = PH_CSIG;
          left = CL_SIG_BYTES;
        end
      end
      PH_CSIG: begin
        r.byte_kind = KIND_CSIG;
        left = left - 16'd1;
        if (left == 16'd0) field = PH_DONE;
      end
      PH_DONE: begin
        r.byte_kind = KIND_DISCARD;
        mark_error(ST_TRAIL);
      end
      default: begin
        r.byte_kind = KIND_DISCARD;
      end
    endcase
    if (fin) begin
      r.verdict_valid = 1'b1;
      if (field == PH_FAIL) r.status = first_err;
      else if (field == PH_DONE) r.status = ST_OK;
      else r.status = ST_TRUNC;
      r.scheme_code = scheme_seen;
      r.hybrid_flag = (scheme_seen & HYBRID_BIT) != 8'h00;
      restart_envelope();
    end
  endtask

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      lens.key_l2 = RST_KEY_L2;
      lens.sig_l2 = RST_SIG_L2;
      lens.key_l3 = RST_KEY_L3;
      lens.sig_l3 = RST_SIG_L3;
      lens.key_l5 = RST_KEY_L5;
      lens.sig_l5 = RST_SIG_L5;
      restart_envelope();
      tags_owed.delete();
      mismatches = 0;
      verdicts_ok = 0;
      verdicts_bad = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_KEY_L2: lens.key_l2 = pwdata[15:0];
          REG_SIG_L2: lens.sig_l2 = pwdata[15:0];
          REG_KEY_L3: lens.key_l3 = pwdata[15:0];
          REG_SIG_L3: lens.sig_l3 = pwdata[15:0];
          REG_KEY_L5: lens.key_l5 = pwdata[15:0];
          REG_SIG_L5: lens.sig_l5 = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tags_owed.size() == 0) begin
          $error("tagged byte %h arrived with no transaction pending", out_ch.byte_value);
          mismatches++;
        end else begin
          want = tags_owed.pop_front();
          if (out_ch.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, got %0d", want.byte_kind, out_ch.byte_kind);
            mismatches++;
          end
          if (out_ch.byte_value !== want.byte_value) begin
            $error("byte_value: expected %h, got %h", want.byte_value, out_ch.byte_value);
            mismatches++;
          end
          if (out_ch.verdict_valid !== want.verdict_valid) begin
            $error("verdict_valid: expected %0d, got %0d", want.verdict_valid,
                   out_ch.verdict_valid);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.scheme_code !== want.scheme_code) begin
            $error("scheme_code: expected %h, got %h", want.scheme_code, out_ch.scheme_code);
            mismatches++;
          end
          if (out_ch.hybrid_flag !== want.hybrid_flag) begin
            $error("hybrid_flag: expected %0d, got %0d", want.hybrid_flag,
                   out_ch.hybrid_flag);
            mismatches++;
          end
          if (want.verdict_valid) begin
            if (want.status == ST_OK) verdicts_ok++;
            else verdicts_bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_envelope_byte(in_ch.env_byte, in_ch.is_final, want);
        tags_owed.insert(tags_owed.size(), want);
      end
    end
    tags_due = tags_owed.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives envelopes into the signature envelope deframer: a short directed
// run at reset and zero lengths, then random envelopes, mostly well formed
// and the rest corrupted, cut short, padded or noise, over several length
// settings and idle patterns. A checker beside the block predicts and
// compares every tagged byte.
// ----------------------------------------------------------------------------
module testbench;
  import sed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned BODY_CAP    = 16;
  localparam int unsigned PHASE_BYTES = 185;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int unsigned mismatches;
  int unsigned tags_due;
  int unsigned verdicts_ok;
  int unsigned verdicts_bad;

  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned envelopes = 0;
  int unsigned settings = 0;
  int send_pct = 0;
  int stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen;
  int unsigned hold_left;

  logic [15:0] key_cfg [1:3];
  logic [15:0] sig_cfg [1:3];
  logic [7:0] env_bytes[$];

  sed_in_if  env_in ();
  sed_out_if tag_out ();

  signature_envelope_deframer u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (env_in),
    .out_ch  (tag_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  deframer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (env_in),
    .out_ch       (tag_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .tags_due     (tags_due),
    .verdicts_ok  (verdicts_ok),
    .verdicts_bad (verdicts_bad)
  );

  always #4 clk = ~clk;

  initial begin
    while (cycles <= LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("signature_envelope_deframer test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    tag_out.ready <= 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        tag_out.ready <= 1'b0;
      end else begin
        tag_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drain();
    env_in.valid <= 1'b0;
    do @(negedge clk); while (tags_due != 0);
    @(posedge clk);
  endtask

  task automatic program_lengths(input logic [15:0] k2, input logic [15:0] s2,
                                 input logic [15:0] k3, input logic [15:0] s3,
                                 input logic [15:0] k5, input logic [15:0] s5);
    wait_drain();
    repeat (4) @(posedge clk);
    apb_write(REG_KEY_L2, k2);
    apb_write(REG_SIG_L2, s2);
    apb_write(REG_KEY_L3, k3);
    apb_write(REG_SIG_L3, s3);
    apb_write(REG_KEY_L5, k5);
    apb_write(REG_SIG_L5, s5);
    key_cfg[LEVEL_2] = k2;
    sig_cfg[LEVEL_2] = s2;
    key_cfg[LEVEL_3] = k3;
    sig_cfg[LEVEL_3] = s3;
    key_cfg[LEVEL_5] = k5;
    sig_cfg[LEVEL_5] = s5;
    settings++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct && gap < 20) gap++;
    if (gap > 0) begin
      env_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    env_in.valid <= 1'b1;
    env_in.env_byte <= b;
    env_in.is_final <= fin;
    do @(posedge clk); while (!env_in.ready);
    bytes_sent++;
  endtask

  task automatic send_envelope(input int pause_at);
    for (int i = 0; i < env_bytes.size(); i++) begin
      if (i == pause_at) wait_drain();
      push_byte(env_bytes[i], i == env_bytes.size() - 1);
    end
    envelopes++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    env_bytes.insert(env_bytes.size(), b);
  endtask

  task automatic add_body(input logic [15:0] len, inout logic capped);
    int n;
    n = (len > BODY_CAP) ? BODY_CAP : len;
    repeat (n) append_byte(8'($urandom));
    if (len > BODY_CAP) capped = 1'b1;
  endtask

  task automatic build_envelope();
    int shape;
    int lvl;
    int sig_pos;
    int cut;
    int nib;
    logic [7:0] sch;
    logic capped;
    env_bytes.delete();
    shape = $urandom_range(99);
    if (shape < 5) begin
      repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
    end else begin
      case ($urandom_range(2))
        0: sch = LEVEL_2;
        1: sch = LEVEL_3;
        default: sch = LEVEL_5;
      endcase
      lvl = sch & LEVEL_MASK;
      if ($urandom_range(3) == 0) sch = sch | HYBRID_BIT;
      capped = 1'b0;
      sig_pos = -1;
      for (int i = 0; i < 4; i++) append_byte(MAGIC_BYTES[i]);
      append_byte(sch);
      append_byte(key_cfg[lvl][15:8]);
      append_byte(key_cfg[lvl][7:0]);
      add_body(key_cfg[lvl], capped);
      if (!capped) begin
        sig_pos = env_bytes.size();
        append_byte(sig_cfg[lvl][15:8]);
        append_byte(sig_cfg[lvl][7:0]);
        add_body(sig_cfg[lvl], capped);
        if (!capped && (sch & HYBRID_BIT) != 8'h00)
          repeat (CL_KEY_BYTES + CL_SIG_BYTES) append_byte(8'($urandom));
      end
      if (shape < 55) begin
        // well formed
      end else if (shape < 62) begin
        cut = $urandom_range(0, 3);
        env_bytes[cut] = env_bytes[cut] ^ 8'($urandom_range(1, 255));
      end else if (shape < 70) begin
        if ($urandom_range(1) == 1) begin
          env_bytes[4] = env_bytes[4] | (8'($urandom_range(1, 7)) << 5);
        end else begin
          nib = $urandom_range(3, 15);
          if (nib == 3) nib = 0;
          env_bytes[4] = {env_bytes[4][7:4], 4'(nib)};
        end
      end else if (shape < 78 || sig_pos < 0) begin
        cut = $urandom_range(5, 6);
        env_bytes[cut] = env_bytes[cut] ^ 8'($urandom_range(1, 255));
      end else if (shape < 86) begin
        cut = sig_pos + $urandom_range(1);
        env_bytes[cut] = env_bytes[cut] ^ 8'($urandom_range(1, 255));
      end else if (shape < 93) begin
        cut = $urandom_range(1, env_bytes.size() - 1);
        while (env_bytes.size() > cut) void'(env_bytes.pop_back());
      end else begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
      end
    end
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 16'h0000;
    if (r < 17) return 16'hFFFF;
    if (r < 22) return 16'($urandom_range(BODY_CAP + 1, 40));
    return 16'($urandom_range(1, 12));
  endfunction

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    env_in.valid <= 1'b0;
    env_in.env_byte <= 8'h00;
    env_in.is_final <= 1'b0;
    key_cfg[LEVEL_2] = RST_KEY_L2;
    sig_cfg[LEVEL_2] = RST_SIG_L2;
    key_cfg[LEVEL_3] = RST_KEY_L3;
    sig_cfg[LEVEL_3] = RST_SIG_L3;
    key_cfg[LEVEL_5] = RST_KEY_L5;
    sig_cfg[LEVEL_5] = RST_SIG_L5;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default lengths, cut short inside the key
    env_bytes = '{MAGIC_BYTES[0], MAGIC_BYTES[1], MAGIC_BYTES[2], MAGIC_BYTES[3],
                  LEVEL_2 | HYBRID_BIT, RST_KEY_L2[15:8], RST_KEY_L2[7:0], 8'hFF};
    send_envelope(-1);

    // zero lengths skip both fields
    program_lengths(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    env_bytes = '{MAGIC_BYTES[0], MAGIC_BYTES[1], MAGIC_BYTES[2], MAGIC_BYTES[3],
                  LEVEL_5, 8'h00, 8'h00, 8'h00, 8'h00};
    send_envelope(-1);
    env_bytes = '{8'hFF};
    send_envelope(-1);
    env_bytes = '{8'h00, 8'h00};
    send_envelope(-1);
    env_bytes = '{MAGIC_BYTES[0], MAGIC_BYTES[1], MAGIC_BYTES[2], MAGIC_BYTES[3], 8'hE1};
    send_envelope(-1);

    for (int p = 0; p < 8; p++) begin
      if (p == 5)
        program_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else
        program_lengths(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                        pick_len());
      case (p % 4)
        0: begin
          send_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_pct = 53;
          stall_pct <= 0;
        end
        2: begin
          send_pct = 0;
          stall_pct <= 53;
        end
        default: begin
          send_pct = 26;
          stall_pct <= 26;
        end
      endcase
      // long receiver hold-off so the block backs up into its input
      if (p == 0) hold_tog <= ~hold_tog;
      for (int unsigned start = bytes_sent; bytes_sent - start < PHASE_BYTES; ) begin
        build_envelope();
        if (p == 2 && bytes_sent == start)
          send_envelope(env_bytes.size() / 2);
        else if ($urandom_range(24) == 0)
          send_envelope($urandom_range(0, env_bytes.size() - 1));
        else
          send_envelope(-1);
      end
    end

    wait_drain();
    repeat (16) @(posedge clk);
    $display("sent %0d envelopes, %0d bytes, over %0d length settings and four idle patterns",
             envelopes, bytes_sent, settings);
    $display("verdicts checked: %0d well formed, %0d rejected", verdicts_ok, verdicts_bad);
    if (mismatches == 0 && tags_due == 0)
      $display("signature_envelope_deframer test passed");
    else
      $display("signature_envelope_deframer test failed");
    $finish;
  end

endmodule
